// ----- src/tlnef_pkg.sv -----
// Shared types, register indexes, character codes and escape expansion for the line filter.
package tlnef_pkg;

	// One input request: a raw text byte and its file-start flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} item_t;

	// One output request: a formatted byte and its end-of-expansion flag
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} text_t;

	// Configuration register indexes (byte address is four times the index)
	localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd0;
	localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
	localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd3;
	localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
	localparam logic [2:0] REG_SHOW_ENDS        = 3'd5;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_UPPERI = 8'h49;
	localparam logic [7:0] CH_UPPERM = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CARET_SHIFT = 8'd64;

	// Expanded form of one character: up to four bytes, bytes[0] goes out first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} char_exp_t;

	// Expand one byte into its visible form under the display options
	function automatic char_exp_t expand_char(input logic [7:0] c, input logic snp,
			input logic tabs, input logic ends);
		char_exp_t  r;
		logic [6:0] low;
		low = c[6:0];
		r.bytes = '0;
		r.count = 3'd1;
		r.bytes[0] = c;
		if (ends && c == CH_LF) begin
			r.bytes[0] = CH_DOLLAR;
			r.bytes[1] = CH_LF;
			r.count = 3'd2;
		end else if (tabs && c == CH_TAB) begin
			r.bytes[0] = CH_CARET;
			r.bytes[1] = CH_UPPERI;
			r.count = 3'd2;
		end else if (snp && c[7]) begin
			r.bytes[0] = CH_UPPERM;
			r.bytes[1] = CH_MINUS;
			if (low < 7'd32) begin
				r.bytes[2] = CH_CARET;
				r.bytes[3] = 8'({1'b0, low} + CARET_SHIFT);
				r.count = 3'd4;
			end else if (low == 7'h7F) begin
				r.bytes[2] = CH_CARET;
				r.bytes[3] = CH_QUEST;
				r.count = 3'd4;
			end else begin
				r.bytes[2] = {1'b0, low};
				r.count = 3'd3;
			end
		end else if (snp && ((c < 8'd32 && c != CH_TAB && c != CH_LF) || c == CH_DEL)) begin
			r.bytes[0] = CH_CARET;
			r.bytes[1] = (c == CH_DEL) ? CH_QUEST : 8'(c + CARET_SHIFT);
			r.count = 3'd2;
		end
		return r;
	endfunction

endpackage

// ----- src/tlnef_bcd.sv -----
// BCD line counter arithmetic: saturating increment and count of significant digits.
module tlnef_bcd #(
	parameter int DIGITS = 10
) (
	input  logic [DIGITS-1:0][3:0]       digits,
	output logic [DIGITS-1:0][3:0]       next_digits,
	output logic [$clog2(DIGITS+1)-1:0]  used
);

	localparam int USED_W = $clog2(DIGITS + 1);

	logic full;
	logic carry;

	// Count digits up to the highest nonzero one, at least one
	always_comb begin
		used = USED_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (digits[i] != 4'd0) begin
				used = USED_W'(i + 1);
			end
		end
	end

	// Increment with decimal carry, hold when every digit is nine
	always_comb begin
		full = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			if (digits[i] != 4'd9) begin
				full = 1'b0;
			end
		end
		carry = 1'b1;
		next_digits = digits;
		for (int i = 0; i < DIGITS; i++) begin
			if (carry) begin
				if (digits[i] >= 4'd9) begin
					next_digits[i] = 4'd0;
				end else begin
					next_digits[i] = digits[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (full) begin
			next_digits = digits;
		end
	end

endmodule

// ----- src/text_line_number_escape_filter_unit.sv -----
// Top level of the text line filter: config port, input register, line state and byte emitter.
// Each input byte is registered, then decoded combinationally against the line state into a
// line-number prefix and an escaped character, which an emitter sends out one byte per cycle
// through an output register while the output is not stalled. An input byte occupies the
// emitter until it has sent every byte it produces: one for a plain byte, up to four for an
// escaped byte, plus the width of the number field (or the number's digit count if larger) and
// a tab at a numbered line start. A squeezed blank line produces nothing and only passes through
// the input register. Plain text therefore streams at one byte per cycle while the output is not
// stalled; longer expansions push back on the input through item_stall. Configuration is written
// over an APB-style port at byte addresses 0 to 20 and should only change while the block is idle.
module text_line_number_escape_filter_unit #(
	parameter int NUMBER_DIGITS      = 10,
	parameter int NUMBER_FIELD_WIDTH = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input requests
	input  logic                 item_valid,
	output logic                 item_stall,
	input  tlnef_pkg::item_t     item,
	// output requests
	output logic                 text_valid,
	input  logic                 text_stall,
	output tlnef_pkg::text_t     text,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int USED_W = $clog2(NUMBER_DIGITS + 1);
	localparam int IDX_W  = $clog2(NUMBER_DIGITS);
	localparam int PAD_W  = $clog2(NUMBER_FIELD_WIDTH + 1);

	// Configuration registers
	logic number_nonblank_q, number_all_q, squeeze_blank_q;
	logic show_nonprinting_q, show_tabs_q, show_ends_q;
	logic [2:0] reg_idx;

	// Input register
	logic             valid_s1;
	tlnef_pkg::item_t item_s1;

	// Line state
	logic                           prev_newline_q;
	logic                           seen_any_q;
	logic [1:0]                     blank_run_q;
	logic [NUMBER_DIGITS-1:0][3:0]  line_digits_q;

	// Emitter
	logic [PAD_W-1:0]               pad_q;
	logic [USED_W-1:0]              dig_q;
	logic                           tab_q;
	logic [3:0][7:0]                chr_q;
	logic [2:0]                     cnt_q;
	logic [NUMBER_DIGITS-1:0][3:0]  num_q;

	// Output register
	logic             text_valid_q;
	tlnef_pkg::text_t text_q;

	// Decode signals
	logic                           eff_pn, eff_sa;
	logic [1:0]                     eff_br, br_next;
	logic [NUMBER_DIGITS-1:0][3:0]  eff_digits, inc_digits;
	logic [USED_W-1:0]              used;
	logic [PAD_W-1:0]               pad_calc;
	logic                           is_lf, at_start, blank, squeezed, show_num;
	tlnef_pkg::char_exp_t           exp_c;

	// Handshake and emitter control
	logic              busy, out_free, emit_fire, emit_last, load_ok, s1_take;
	logic [USED_W-1:0] dig_dec;
	logic [IDX_W-1:0]  dig_idx;
	logic [7:0]        emit_byte;

	// Config port: write on access phase, read back by index
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_nonblank_q  <= 1'b0;
			number_all_q       <= 1'b0;
			squeeze_blank_q    <= 1'b0;
			show_nonprinting_q <= 1'b0;
			show_tabs_q        <= 1'b0;
			show_ends_q        <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				tlnef_pkg::REG_NUMBER_NONBLANK:  number_nonblank_q  <= pwdata[0];
				tlnef_pkg::REG_NUMBER_ALL:       number_all_q       <= pwdata[0];
				tlnef_pkg::REG_SQUEEZE_BLANK:    squeeze_blank_q    <= pwdata[0];
				tlnef_pkg::REG_SHOW_NONPRINTING: show_nonprinting_q <= pwdata[0];
				tlnef_pkg::REG_SHOW_TABS:        show_tabs_q        <= pwdata[0];
				tlnef_pkg::REG_SHOW_ENDS:        show_ends_q        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			tlnef_pkg::REG_NUMBER_NONBLANK:  prdata[0] = number_nonblank_q;
			tlnef_pkg::REG_NUMBER_ALL:       prdata[0] = number_all_q;
			tlnef_pkg::REG_SQUEEZE_BLANK:    prdata[0] = squeeze_blank_q;
			tlnef_pkg::REG_SHOW_NONPRINTING: prdata[0] = show_nonprinting_q;
			tlnef_pkg::REG_SHOW_TABS:        prdata[0] = show_tabs_q;
			tlnef_pkg::REG_SHOW_ENDS:        prdata[0] = show_ends_q;
			default: prdata = '0;
		endcase
	end

	// Handshake: the emitter takes a new request when idle or sending its final byte
	assign busy       = (cnt_q != 3'd0);
	assign out_free   = !text_valid_q || !text_stall;
	assign emit_fire  = busy && out_free;
	assign emit_last  = (pad_q == '0) && (dig_q == '0) && !tab_q && (cnt_q == 3'd1);
	assign load_ok    = !busy || (emit_fire && emit_last);
	assign s1_take    = valid_s1 && load_ok;
	assign item_stall = valid_s1 && !load_ok;

	// Input register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Decode: apply file start, classify the line, pick number and escape form
	always_comb begin
		eff_pn     = item_s1.file_start ? 1'b0 : prev_newline_q;
		eff_sa     = item_s1.file_start ? 1'b0 : seen_any_q;
		eff_br     = item_s1.file_start ? 2'd0 : blank_run_q;
		eff_digits = line_digits_q;
		if (item_s1.file_start) begin
			eff_digits    = '0;
			eff_digits[0] = 4'd1;
		end
		is_lf    = (item_s1.data_byte == tlnef_pkg::CH_LF);
		at_start = eff_pn || !eff_sa;
		blank    = is_lf && at_start;
		if (!blank) begin
			br_next = 2'd0;
		end else if (eff_br < 2'd2) begin
			br_next = eff_br + 2'd1;
		end else begin
			br_next = 2'd2;
		end
		squeezed = squeeze_blank_q && blank && (br_next > 2'd1);
		show_num = at_start && (number_nonblank_q ? !blank : number_all_q);
		exp_c    = tlnef_pkg::expand_char(item_s1.data_byte, show_nonprinting_q,
				show_tabs_q, show_ends_q);
		pad_calc = '0;
		if (int'(used) < NUMBER_FIELD_WIDTH) begin
			pad_calc = PAD_W'(NUMBER_FIELD_WIDTH - int'(used));
		end
	end

	tlnef_bcd #(
		.DIGITS(NUMBER_DIGITS)
	) u_bcd (
		.digits      (eff_digits),
		.next_digits (inc_digits),
		.used        (used)
	);

	// Line state: advance when the decoded request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_newline_q <= 1'b0;
			seen_any_q     <= 1'b0;
			blank_run_q    <= 2'd0;
			line_digits_q  <= {{(NUMBER_DIGITS-1){4'd0}}, 4'd1};
		end else if (s1_take) begin
			seen_any_q     <= 1'b1;
			blank_run_q    <= br_next;
			prev_newline_q <= squeezed ? eff_pn : is_lf;
			line_digits_q  <= (show_num && !squeezed) ? inc_digits : eff_digits;
		end
	end

	// Emitter: spaces, then digits from the top, then tab, then the character bytes
	assign dig_dec = dig_q - USED_W'(1);
	assign dig_idx = dig_dec[IDX_W-1:0];

	always_comb begin
		priority if (pad_q != '0) begin
			emit_byte = tlnef_pkg::CH_SPACE;
		end else if (dig_q != '0) begin
			emit_byte = 8'(tlnef_pkg::CH_ZERO + {4'd0, num_q[dig_idx]});
		end else if (tab_q) begin
			emit_byte = tlnef_pkg::CH_TAB;
		end else begin
			emit_byte = chr_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
			dig_q <= '0;
			tab_q <= 1'b0;
			cnt_q <= 3'd0;
		end else if (s1_take && !squeezed) begin
			// load the next request unless it is squeezed away
			pad_q <= show_num ? pad_calc : '0;
			dig_q <= show_num ? used : '0;
			tab_q <= show_num;
			cnt_q <= exp_c.count;
		end else if (emit_fire) begin
			// advance one byte
			priority if (pad_q != '0) begin
				pad_q <= pad_q - PAD_W'(1);
			end else if (dig_q != '0) begin
				dig_q <= dig_q - USED_W'(1);
			end else if (tab_q) begin
				tab_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && !squeezed) begin
			chr_q <= exp_c.bytes;
			num_q <= eff_digits;
		end else if (emit_fire && pad_q == '0 && dig_q == '0 && !tab_q) begin
			chr_q <= {8'h00, chr_q[3:1]};
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (emit_fire) begin
			text_valid_q <= 1'b1;
		end else if (!text_stall) begin
			text_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			text_q.out_byte <= emit_byte;
			text_q.last     <= emit_last;
		end
	end

	assign text_valid = text_valid_q;
	assign text       = text_q;

	// A loaded request leaves the emitter busy in the cycle after the load
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_take && !squeezed) |=> busy)
		else $error("emitter idle right after a load");

	// The final byte frees the emitter when nothing new is loaded
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && emit_last && !s1_take) |=> !busy)
		else $error("emitter still busy after final byte");

	// Before any byte arrives the line state stays at its reset values
	a_fresh_state: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_any_q |-> (!prev_newline_q && blank_run_q == 2'd0))
		else $error("line state changed without any input");

	// The blank-line run counter saturates at two
	a_blank_sat: assert property (@(posedge clk) disable iff (!arst_n)
		blank_run_q != 2'd3)
		else $error("blank run counter overflow");

endmodule

// ----- dv/text_line_number_escape_filter_unit_tb.sv -----
// Self-checking testbench for the text line filter: edge cases and random text through several option settings.
`timescale 1ns / 1ps

module text_line_number_escape_filter_unit_tb;

	localparam int NUM_DIGITS  = 10;
	localparam int FIELD_WIDTH = 6;

	// Expected formatted text for every accepted request, plus the line state behind it
	class line_filter_ledger;
		bit                 number_nonblank, number_all, squeeze_blank;
		bit                 show_nonprinting, show_tabs, show_ends;
		bit                 prev_newline, seen_any;
		bit [1:0]           blank_run;
		bit [39:0]          line_digits;
		bit [7:0]           burst[$];
		tlnef_pkg::text_t   owed_text[$];
		int                 errors;

		function new();
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			prev_newline = 1'b0;
			seen_any = 1'b0;
			blank_run = 2'd0;
			line_digits = 40'd1;
		endfunction

		function void set_option(logic [2:0] idx, bit v);
			case (idx)
				tlnef_pkg::REG_NUMBER_NONBLANK:  number_nonblank = v;
				tlnef_pkg::REG_NUMBER_ALL:       number_all = v;
				tlnef_pkg::REG_SQUEEZE_BLANK:    squeeze_blank = v;
				tlnef_pkg::REG_SHOW_NONPRINTING: show_nonprinting = v;
				tlnef_pkg::REG_SHOW_TABS:        show_tabs = v;
				tlnef_pkg::REG_SHOW_ENDS:        show_ends = v;
				default: ;
			endcase
		endfunction

		// Right-justify the line number, no leading zeros, then a tab
		function void push_number();
			int used;
			used = 1;
			for (int i = 0; i < NUM_DIGITS; i++)
				if (line_digits[4*i +: 4] != 4'd0)
					used = i + 1;
			for (int i = used; i < FIELD_WIDTH; i++)
				burst.push_back(tlnef_pkg::CH_SPACE);
			for (int i = used; i > 0; i--)
				burst.push_back(tlnef_pkg::CH_ZERO + {4'h0, line_digits[4*(i-1) +: 4]});
			burst.push_back(tlnef_pkg::CH_TAB);
		endfunction

		// Increment the BCD line number, hold it once every digit is nine
		function void advance_number();
			bit full;
			full = 1'b1;
			for (int i = 0; i < NUM_DIGITS; i++)
				if (line_digits[4*i +: 4] != 4'd9)
					full = 1'b0;
			if (full)
				return;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (line_digits[4*i +: 4] >= 4'd9) begin
					line_digits[4*i +: 4] = 4'd0;
				end else begin
					line_digits[4*i +: 4] = line_digits[4*i +: 4] + 4'd1;
					return;
				end
			end
		endfunction

		function void push_escaped(bit [7:0] c);
			bit [7:0] low;
			low = {1'b0, c[6:0]};
			if (show_ends && c == tlnef_pkg::CH_LF) begin
				burst.push_back(tlnef_pkg::CH_DOLLAR);
				burst.push_back(tlnef_pkg::CH_LF);
			end else if (show_tabs && c == tlnef_pkg::CH_TAB) begin
				burst.push_back(tlnef_pkg::CH_CARET);
				burst.push_back(tlnef_pkg::CH_UPPERI);
			end else if (show_nonprinting && c[7]) begin
				burst.push_back(tlnef_pkg::CH_UPPERM);
				burst.push_back(tlnef_pkg::CH_MINUS);
				if (low < 8'd32) begin
					burst.push_back(tlnef_pkg::CH_CARET);
					burst.push_back(low + tlnef_pkg::CARET_SHIFT);
				end else if (low == tlnef_pkg::CH_DEL) begin
					burst.push_back(tlnef_pkg::CH_CARET);
					burst.push_back(tlnef_pkg::CH_QUEST);
				end else begin
					burst.push_back(low);
				end
			end else if (show_nonprinting && ((c < 8'd32 && c != tlnef_pkg::CH_TAB
					&& c != tlnef_pkg::CH_LF) || c == tlnef_pkg::CH_DEL)) begin
				burst.push_back(tlnef_pkg::CH_CARET);
				burst.push_back((c == tlnef_pkg::CH_DEL) ? tlnef_pkg::CH_QUEST
					: c + tlnef_pkg::CARET_SHIFT);
			end else begin
				burst.push_back(c);
			end
		endfunction

		// Work out the bytes one accepted request causes and queue them
		function void note_request(tlnef_pkg::item_t it);
			bit [7:0] c;
			bit       at_start, blank;
			c = it.data_byte;
			burst.delete();
			if (it.file_start)
				clear_line();
			at_start = prev_newline || !seen_any;
			blank = (c == tlnef_pkg::CH_LF) && at_start;
			seen_any = 1'b1;
			if (blank) begin
				if (blank_run < 2'd2)
					blank_run++;
			end else begin
				blank_run = 2'd0;
			end
			// drop repeated blank lines, line number and newline flag stay as they were
			if (squeeze_blank && blank && blank_run > 2'd1)
				return;
			if (at_start && ((number_nonblank && !blank) || (!number_nonblank && number_all))) begin
				push_number();
				advance_number();
			end
			push_escaped(c);
			prev_newline = (c == tlnef_pkg::CH_LF);
			foreach (burst[i])
				owed_text.push_back(tlnef_pkg::text_t'{out_byte: burst[i],
					last: (i == burst.size() - 1)});
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_text(tlnef_pkg::text_t got);
			tlnef_pkg::text_t want;
			if (owed_text.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
				return;
			end
			want = owed_text.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b (byte %02h)", got.last, want.last,
					want.out_byte));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	tlnef_pkg::item_t  item = '0;
	logic              text_valid;
	logic              text_stall = 1'b0;
	tlnef_pkg::text_t  text;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [4:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	line_filter_ledger ledger = new();

	text_line_number_escape_filter_unit #(
		.NUMBER_DIGITS      (NUM_DIGITS),
		.NUMBER_FIELD_WIDTH (FIELD_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	// Note each accepted request
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			ledger.note_request(item);
	end

	// Check each accepted output byte
	always @(posedge clk) begin
		if (arst_n && text_valid && !text_stall)
			ledger.check_text(text);
	end

	// Stall the output at random
	always @(posedge clk) begin
		text_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// Write one register: setup phase, then access phase until pready
	task apb_write(logic [2:0] idx, bit v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {31'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_option(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task apply_options(bit [5:0] opts);
		apb_write(tlnef_pkg::REG_NUMBER_NONBLANK, opts[tlnef_pkg::REG_NUMBER_NONBLANK]);
		apb_write(tlnef_pkg::REG_NUMBER_ALL, opts[tlnef_pkg::REG_NUMBER_ALL]);
		apb_write(tlnef_pkg::REG_SQUEEZE_BLANK, opts[tlnef_pkg::REG_SQUEEZE_BLANK]);
		apb_write(tlnef_pkg::REG_SHOW_NONPRINTING, opts[tlnef_pkg::REG_SHOW_NONPRINTING]);
		apb_write(tlnef_pkg::REG_SHOW_TABS, opts[tlnef_pkg::REG_SHOW_TABS]);
		apb_write(tlnef_pkg::REG_SHOW_ENDS, opts[tlnef_pkg::REG_SHOW_ENDS]);
	endtask

	// Hold one request until accepted, after an optional random gap
	task send_request(tlnef_pkg::item_t it);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
	endtask

	// Drop valid and let every owed byte drain, plus a squeezed byte in flight
	task drain_text();
		item_valid <= 1'b0;
		while (ledger.owed_text.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Text-like byte: printable most often, frequent newlines, some tabs, control and high bytes
	function automatic tlnef_pkg::item_t text_request();
		tlnef_pkg::item_t it;
		int unsigned      pick;
		pick = $urandom_range(99);
		if (pick < 42)      it.data_byte = 8'($urandom_range(8'h20, 8'h7E));
		else if (pick < 67) it.data_byte = tlnef_pkg::CH_LF;
		else if (pick < 73) it.data_byte = tlnef_pkg::CH_TAB;
		else if (pick < 80) it.data_byte = 8'($urandom_range(0, 31));
		else if (pick < 88) it.data_byte = 8'($urandom_range(8'h80, 8'hFE));
		else if (pick < 91) it.data_byte = 8'hFF;
		else if (pick < 94) it.data_byte = tlnef_pkg::CH_DEL;
		else                it.data_byte = 8'($urandom);
		it.file_start = ($urandom_range(99) < 4);
		return it;
	endfunction

	task run_phase(int phase, bit [5:0] opts, int count);
		drain_text();
		if (phase < 3) begin
			send_idle_pct = 30;
			recv_stall_pct = 72;
		end else if (phase < 5) begin
			send_idle_pct = 72;
			recv_stall_pct = 30;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		apply_options(opts);
		for (int i = 0; i < count; i++) begin
			// hold off once mid-phase until the output has fully caught up
			if (phase == 2 && i == count / 2) begin
				item_valid <= 1'b0;
				while (ledger.owed_text.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			send_request(text_request());
		end
	endtask

	// Edge cases: blank runs, tab, control bytes, DEL, high bytes, high DEL, file start
	logic [8:0] edge_script [20] = '{
		{8'h41, 1'b1}, {tlnef_pkg::CH_LF, 1'b0}, {tlnef_pkg::CH_LF, 1'b0},
		{tlnef_pkg::CH_LF, 1'b0}, {tlnef_pkg::CH_TAB, 1'b0},
		{8'h00, 1'b0}, {8'h1F, 1'b0}, {tlnef_pkg::CH_DEL, 1'b0}, {8'h80, 1'b0}, {8'h9F, 1'b0},
		{8'hA0, 1'b0}, {8'hFE, 1'b0}, {8'hFF, 1'b0}, {tlnef_pkg::CH_SPACE, 1'b0}, {8'h7E, 1'b0},
		{tlnef_pkg::CH_LF, 1'b0}, {tlnef_pkg::CH_LF, 1'b1}, {tlnef_pkg::CH_LF, 1'b0},
		{8'h78, 1'b0}, {tlnef_pkg::CH_LF, 1'b0}
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// addresses past the last register must be ignored
		apb_write(tlnef_pkg::REG_SHOW_ENDS + 3'd1, 1'b1);
		apb_write(tlnef_pkg::REG_SHOW_ENDS + 3'd2, 1'b1);

		send_idle_pct = 30;
		recv_stall_pct = 72;
		apply_options(6'b111111);
		foreach (edge_script[i])
			send_request(tlnef_pkg::item_t'(edge_script[i]));

		run_phase(0, 6'b000000, 27);
		run_phase(1, 6'b111111, 27);
		run_phase(2, 6'($urandom), 27);
		run_phase(3, 6'b000110, 27);
		run_phase(4, 6'($urandom), 27);
		run_phase(5, 6'($urandom), 27);

		item_valid <= 1'b0;
		while (ledger.owed_text.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#500000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
